[design/webm_cluster_recovery_scanner_unit_assert.svh]
// assertion macros shared by the scanner block
`ifndef WEBM_CLUSTER_RECOVERY_SCANNER_UNIT_ASSERT_SVH
`define WEBM_CLUSTER_RECOVERY_SCANNER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WCRS_ASSERT_IMP(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("wcrs same-cycle check failed");

// next-cycle implication, checked outside reset
`define WCRS_ASSERT_NXT(name, clk_sig, rst_sig, ante, cons) \
  name: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("wcrs next-cycle check failed");

`endif

[design/wcrs_pkg.sv]
`default_nettype none

package wcrs_pkg;

  // offset arithmetic width, positions wrap modulo 2^OFFSET_BITS
  localparam int OFFSET_BITS = 40;
  // width of the offset fields in a result
  localparam int RES_OFS_W = 40;

  localparam logic [15:0] HEADER_BYTES_RESET = 16'd256;
  localparam logic [15:0] MIN_HEADER_BYTES = 16'd4;

  // cluster head layout
  localparam logic [4:0] FRAME_AT = 5'd23;
  localparam logic [4:0] SIZE_AT = 5'd4;
  localparam logic [4:0] TC_ID_AT = 5'd8;
  localparam logic [4:0] TC_FIRST = 5'd10;
  localparam logic [4:0] TC_LAST = 5'd13;
  localparam int SEG_SIZE_AT = 40;
  localparam int ID_SIZE_BYTES = 8;

  localparam logic [7:0] SIZE_NIBBLE_MASK = 8'hF0;
  localparam logic [7:0] SIZE_NIBBLE_ONE = 8'h10;
  localparam logic [27:0] SIZE_MASK = 28'hFFFFFFF;
  localparam logic [7:0] TC_ID = 8'hE7;
  localparam logic [7:0] FRAME_MASK = 8'hC0;
  localparam logic [7:0] FRAME_MARK = 8'h80;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } step_t;

  typedef struct packed {
    logic                 status;
    logic [31:0]          frames_kept;
    logic [RES_OFS_W-1:0] whole_end;
    logic [31:0]          last_timecode_ms;
    logic [RES_OFS_W-1:0] segment_size;
  } result_t;

  // ebml magic 1A 45 DF A3
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'h1A;
      2'd1:    v = 8'h45;
      2'd2:    v = 8'hDF;
      default: v = 8'hA3;
    endcase
    return v;
  endfunction

  // cluster id 1F 43 B6 75
  function automatic logic [7:0] cluster_id_byte(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'h1F;
      2'd1:    v = 8'h43;
      2'd2:    v = 8'hB6;
      default: v = 8'h75;
    endcase
    return v;
  endfunction

  // fit an offset into the result field width
  function automatic logic [RES_OFS_W-1:0] to_res_ofs(input logic [OFFSET_BITS-1:0] x);
    logic [63:0] w;
    w = 64'(x);
    return w[RES_OFS_W-1:0];
  endfunction

endpackage

`default_nettype wire

[design/wcrs_if.sv]
`default_nettype none

// byte stream channel
interface wcrs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// scan summary channel
interface wcrs_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [31:0]                   frames_kept;
  logic [wcrs_pkg::RES_OFS_W-1:0] whole_end;
  logic [31:0]                   last_timecode_ms;
  logic [wcrs_pkg::RES_OFS_W-1:0] segment_size;
  modport source (output valid, output status, output frames_kept, output whole_end,
                  output last_timecode_ms, output segment_size, input ready);
  modport sink (input valid, input status, input frames_kept, input whole_end,
                input last_timecode_ms, input segment_size, output ready);
endinterface

// header length write channel
interface wcrs_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] header_bytes;
  modport source (output valid, output header_bytes, input ready);
  modport sink (input valid, input header_bytes, output ready);
endinterface

`default_nettype wire

[design/webm_cluster_recovery_scanner_unit.sv]
// WebM cluster recovery scanner
// feed: one file byte per transaction (data_byte, last_byte marks the final byte).
// report: one summary transaction per file, produced for the byte marked last_byte:
//   status, frames_kept, whole_end, last_timecode_ms, segment_size.
// setup: writes header_bytes (offset of the first cluster), always ready; write
//   only while no byte is in flight and no summary is waiting.
// throughput: one byte per cycle while feed is not stalled; every byte passes an
//   input register and then a single update of the scan state, so feed can
//   stream back to back. output: a last byte passes the input register and then
//   the output register, where its summary sits until report.ready; meanwhile
//   feed keeps taking ordinary bytes, and stalls only when a second last byte
//   would need the occupied output register.
// reset: header_bytes returns to 256, the scan returns to the magic check at
//   offset zero, and the input and output registers empty. After each last
//   byte the scan state clears on its own and the next byte starts a new file.
`default_nettype none

`include "webm_cluster_recovery_scanner_unit_assert.svh"

module webm_cluster_recovery_scanner_unit (
  input logic        clk,
  input logic        rst,
  wcrs_in_if.sink    feed,
  wcrs_out_if.source report,
  wcrs_cfg_if.sink   setup
);
  import wcrs_pkg::*;

  logic        s1_valid;
  step_t       s1_step;
  logic        s1_fire;
  logic        res_valid;
  result_t     res;
  result_t     core_result;
  logic [15:0] header_bytes;

  // header length register
  assign setup.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes <= HEADER_BYTES_RESET;
    end else if (setup.valid) begin
      header_bytes <= setup.header_bytes;
    end
  end

  // input register, drains unless a last byte meets a full output register
  assign s1_fire    = s1_valid && (!s1_step.last_byte || !res_valid || report.ready);
  assign feed.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (feed.ready) begin
      s1_valid <= feed.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (feed.ready && feed.valid) begin
      s1_step.data_byte <= feed.data_byte;
      s1_step.last_byte <= feed.last_byte;
    end
  end

  wcrs_scan_core u_core (
    .clk          (clk),
    .rst          (rst),
    .header_bytes (header_bytes),
    .step_valid   (s1_fire),
    .step         (s1_step),
    .result       (core_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_fire && s1_step.last_byte) begin
      res_valid <= 1'b1;
    end else if (report.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_step.last_byte) begin
      res <= core_result;
    end
  end

  assign report.valid            = res_valid;
  assign report.status           = res.status;
  assign report.frames_kept      = res.frames_kept;
  assign report.whole_end        = res.whole_end;
  assign report.last_timecode_ms = res.last_timecode_ms;
  assign report.segment_size     = res.segment_size;

  // status agrees with the frame count
  `WCRS_ASSERT_IMP(a_status_count, clk, rst, report.valid, report.status == (report.frames_kept == 32'd0))
  // a file without whole clusters carries no timecode and no segment size
  `WCRS_ASSERT_IMP(a_empty_summary, clk, rst, report.valid && report.status, (report.segment_size == '0) && (report.last_timecode_ms == 32'd0))
  // a held byte stays in the input register unchanged
  `WCRS_ASSERT_NXT(a_s1_hold, clk, rst, s1_valid && !s1_fire, s1_valid && $stable(s1_step))

endmodule

`default_nettype wire

[design/wcrs_scan_core.sv]
`default_nettype none

module wcrs_scan_core (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       header_bytes,
  input  logic              step_valid,
  input  wcrs_pkg::step_t   step,
  output wcrs_pkg::result_t result
);
  import wcrs_pkg::*;

  localparam logic [2:0] PH_MAGIC  = 3'd0;
  localparam logic [2:0] PH_HEADER = 3'd1;
  localparam logic [2:0] PH_HEAD   = 3'd2;
  localparam logic [2:0] PH_BODY   = 3'd3;
  localparam logic [2:0] PH_STOP   = 3'd4;

  logic [OFFSET_BITS-1:0] byte_position, byte_position_next;
  logic [2:0]             scan_phase, scan_phase_next;
  logic [4:0]             head_index, head_index_next;
  logic [27:0]            captured_size, captured_size_next;
  logic [31:0]            captured_timecode, captured_timecode_next;
  logic [OFFSET_BITS-1:0] cluster_end, cluster_end_next;
  logic [OFFSET_BITS-1:0] kept_end, kept_end_next;
  logic [31:0]            frame_count, frame_count_next;
  logic [31:0]            kept_timecode, kept_timecode_next;

  logic [OFFSET_BITS-1:0] pos_inc;
  logic [15:0]            hb;
  logic [7:0]             b;
  logic [27:0]            size_shift;
  logic                   end_hit;
  logic                   do_keep;

  assign b          = step.data_byte;
  assign pos_inc    = byte_position + OFFSET_BITS'(1);
  assign hb         = (header_bytes < MIN_HEADER_BYTES) ? MIN_HEADER_BYTES : header_bytes;
  assign size_shift = {captured_size[19:0], b} & SIZE_MASK;
  assign end_hit    = (pos_inc == cluster_end);

  // per-byte scan update
  always_comb begin
    scan_phase_next        = scan_phase;
    head_index_next        = head_index;
    captured_size_next     = captured_size;
    captured_timecode_next = captured_timecode;
    cluster_end_next       = cluster_end;
    kept_end_next          = kept_end;
    frame_count_next       = frame_count;
    kept_timecode_next     = kept_timecode;
    do_keep                = 1'b0;

    unique case (scan_phase)
      PH_MAGIC: begin
        if ((byte_position[OFFSET_BITS-1:2] != '0) ||
            (b != magic_byte(byte_position[1:0]))) begin
          scan_phase_next = PH_STOP;
        end else if (byte_position[1:0] == 2'd3) begin
          if (hb == MIN_HEADER_BYTES) begin
            kept_end_next   = OFFSET_BITS'(hb);
            scan_phase_next = PH_HEAD;
            head_index_next = '0;
          end else begin
            scan_phase_next = PH_HEADER;
          end
        end
      end
      PH_HEADER: begin
        if (pos_inc == OFFSET_BITS'(hb)) begin
          kept_end_next   = OFFSET_BITS'(hb);
          scan_phase_next = PH_HEAD;
          head_index_next = '0;
        end
      end
      PH_HEAD: begin
        head_index_next = head_index + 5'd1;
        if (head_index < SIZE_AT) begin
          if (b != cluster_id_byte(head_index[1:0])) scan_phase_next = PH_STOP;
        end else if (head_index == SIZE_AT) begin
          if ((b & SIZE_NIBBLE_MASK) != SIZE_NIBBLE_ONE) begin
            scan_phase_next = PH_STOP;
          end else begin
            captured_size_next = {24'd0, b[3:0]};
          end
        end else if (head_index < TC_ID_AT) begin
          captured_size_next = size_shift;
          if (head_index == TC_ID_AT - 5'd1) begin
            if (size_shift <= 28'(FRAME_AT - 5'(ID_SIZE_BYTES))) begin
              scan_phase_next = PH_STOP;
            end else begin
              cluster_end_next = kept_end + OFFSET_BITS'(ID_SIZE_BYTES)
                                 + OFFSET_BITS'(size_shift);
            end
          end
        end else if (head_index == TC_ID_AT) begin
          if (b != TC_ID) scan_phase_next = PH_STOP;
        end else if ((head_index >= TC_FIRST) && (head_index <= TC_LAST)) begin
          captured_timecode_next = {captured_timecode[23:0], b};
        end else if (head_index == FRAME_AT) begin
          head_index_next = head_index;
          if ((b & FRAME_MASK) != FRAME_MARK) begin
            scan_phase_next = PH_STOP;
          end else if (end_hit) begin
            do_keep = 1'b1;
          end else begin
            scan_phase_next = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (end_hit) do_keep = 1'b1;
      end
      default: begin
      end
    endcase

    // whole cluster seen
    if (do_keep) begin
      if (frame_count != '1) frame_count_next = frame_count + 32'd1;
      kept_timecode_next = captured_timecode;
      kept_end_next      = cluster_end;
      scan_phase_next    = PH_HEAD;
      head_index_next    = '0;
    end
  end

  assign byte_position_next = pos_inc;

  // summary from the state after this byte
  always_comb begin
    result.status           = (frame_count_next == '0);
    result.frames_kept      = frame_count_next;
    result.whole_end        = to_res_ofs(kept_end_next);
    result.last_timecode_ms = kept_timecode_next;
    if ((frame_count_next != '0) && (kept_end_next >= OFFSET_BITS'(SEG_SIZE_AT + 8))) begin
      result.segment_size = to_res_ofs(kept_end_next - OFFSET_BITS'(SEG_SIZE_AT + 8));
    end else begin
      result.segment_size = '0;
    end
  end

  // scan state, cleared at reset and after the last byte of a file
  always_ff @(posedge clk) begin
    if (rst || (step_valid && step.last_byte)) begin
      byte_position     <= '0;
      scan_phase        <= PH_MAGIC;
      head_index        <= '0;
      captured_size     <= '0;
      captured_timecode <= '0;
      cluster_end       <= '0;
      kept_end          <= '0;
      frame_count       <= '0;
      kept_timecode     <= '0;
    end else if (step_valid) begin
      byte_position     <= byte_position_next;
      scan_phase        <= scan_phase_next;
      head_index        <= head_index_next;
      captured_size     <= captured_size_next;
      captured_timecode <= captured_timecode_next;
      cluster_end       <= cluster_end_next;
      kept_end          <= kept_end_next;
      frame_count       <= frame_count_next;
      kept_timecode     <= kept_timecode_next;
    end
  end

endmodule

`default_nettype wire
